// ===== rtl/ffea_pkg.sv =====
// Package for the first-fit extent allocator: sizes, codes, state type and mask helper.
package ffea_pkg;

   localparam int NUM_SECTORS = 32;
   localparam int IDX_W       = $clog2(NUM_SECTORS);
   localparam int LIM_W       = 7;

   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   localparam logic [1:0] STATUS_DONE    = 2'd0;
   localparam logic [1:0] STATUS_NOSPACE = 2'd1;
   localparam logic [1:0] STATUS_BADFREE = 2'd2;

   typedef enum logic [0:0] {
      ST_IDLE,
      ST_SCAN
   } state_type;

   function automatic logic [NUM_SECTORS-1:0] range_mask(input logic [LIM_W-1:0] lo,
                                                        input logic [LIM_W-1:0] hi);
      logic [NUM_SECTORS-1:0] m;
      m = '0;
      for (int k = 0; k < NUM_SECTORS; k++) begin
         m[k] = (LIM_W'(k) >= lo) && (LIM_W'(k) <= hi);
      end
      return m;
   endfunction

endpackage

// ===== rtl/first_fit_extent_allocator.sv =====
// First-fit sector allocator over a free bitmap with one-sector-per-cycle scan.
//
//   channel   ports                                        transfer
//   request   start, busy, req_op, req_count,               start high, busy low
//             req_start_sector, req_last_sector
//   result    rsp_valid, rsp_status, rsp_run_first,         rsp_valid high, one cycle
//             rsp_run_last
//
// A free request, or an allocate with count zero, is answered from idle; busy stays low.
// An allocate with a nonzero count enters the scan, where one map bit is examined per
// cycle by the shared run counter and compare until a run reaches count or the map ends.
// The result strobe comes in the cycle after the last one of the item.
// Reset sets every sector free and clears the sequencer; results are never stalled.
module first_fit_extent_allocator
   import ffea_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  logic       req_op,
   input  logic [5:0] req_count,
   input  logic [4:0] req_start_sector,
   input  logic [4:0] req_last_sector,
   output logic       rsp_valid,
   output logic [1:0] rsp_status,
   output logic [4:0] rsp_run_first,
   output logic [4:0] rsp_run_last
);

   state_type              state_ff, state_in;
   logic [NUM_SECTORS-1:0] map_ff, map_in;
   logic [IDX_W-1:0]       idx_ff, idx_in;
   logic [LIM_W-1:0]       len_ff, len_in;
   logic [IDX_W-1:0]       run_start_ff, run_start_in;
   logic [5:0]             count_ff, count_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [1:0]             rsp_status_ff, rsp_status_in;
   logic [4:0]             rsp_first_ff, rsp_first_in;
   logic [4:0]             rsp_last_ff, rsp_last_in;

   logic                   accept;
   logic                   cur_bit;
   logic [LIM_W-1:0]       len_next;
   logic [IDX_W-1:0]       start_next;
   logic                   found;
   logic                   at_end;
   logic                   free_bad;

   assign accept     = start && (state_ff == ST_IDLE);
   assign cur_bit    = map_ff[idx_ff];
   assign len_next   = cur_bit ? (len_ff + LIM_W'(1)) : '0;
   assign start_next = (cur_bit && (len_ff == '0)) ? idx_ff : run_start_ff;
   assign found      = cur_bit && (len_next >= LIM_W'(count_ff));
   assign at_end     = (idx_ff == IDX_W'(NUM_SECTORS - 1));
   assign free_bad   = (req_start_sector > req_last_sector) ||
                       (LIM_W'(req_last_sector) >= LIM_W'(NUM_SECTORS));

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && (req_op == OP_ALLOC) && (req_count != '0)) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (found || at_end) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      map_in        = map_ff;
      idx_in        = idx_ff;
      len_in        = len_ff;
      run_start_in  = run_start_ff;
      count_in      = count_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_first_in  = rsp_first_ff;
      rsp_last_in   = rsp_last_ff;
      unique case (state_ff)
         ST_IDLE: begin
            idx_in       = '0;
            len_in       = '0;
            run_start_in = '0;
            count_in     = req_count;
            if (accept) begin
               if (req_op == OP_FREE) begin
                  rsp_valid_in = 1'b1;
                  rsp_first_in = '0;
                  rsp_last_in  = '0;
                  if (free_bad) begin
                     rsp_status_in = STATUS_BADFREE;
                  end else begin
                     rsp_status_in = STATUS_DONE;
                     map_in = map_ff | range_mask(LIM_W'(req_start_sector),
                                                  LIM_W'(req_last_sector));
                  end
               end else if (req_count == '0) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = STATUS_NOSPACE;
                  rsp_first_in  = '0;
                  rsp_last_in   = '0;
               end
            end
         end
         ST_SCAN: begin
            idx_in       = idx_ff + IDX_W'(1);
            len_in       = len_next;
            run_start_in = start_next;
            if (found) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = STATUS_DONE;
               rsp_first_in  = 5'(start_next);
               rsp_last_in   = 5'(idx_ff);
               map_in = map_ff & ~range_mask(LIM_W'(start_next), LIM_W'(idx_ff));
            end else if (at_end) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = STATUS_NOSPACE;
               rsp_first_in  = '0;
               rsp_last_in   = '0;
            end
         end
         default: begin
            rsp_valid_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         map_ff       <= '1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         map_ff       <= map_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      len_ff        <= len_in;
      run_start_ff  <= run_start_in;
      count_ff      <= count_in;
      rsp_status_ff <= rsp_status_in;
      rsp_first_ff  <= rsp_first_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign busy          = (state_ff != ST_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_run_first = rsp_first_ff;
   assign rsp_run_last  = rsp_last_ff;

   a_scan_advance: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) && $past(state_ff == ST_SCAN) && !$past(reset)
      |-> idx_ff == $past(idx_ff) + IDX_W'(1))
      else $error("scan index did not advance by one");

   a_map_hold_scan: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) && $past(state_ff == ST_SCAN) && !$past(reset)
      |-> $stable(map_ff))
      else $error("free map changed during scan");

   a_zero_on_fail: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != STATUS_DONE)
      |-> (rsp_run_first == '0) && (rsp_run_last == '0))
      else $error("run bounds nonzero on failed request");

   a_run_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_run_last >= rsp_run_first)
      else $error("run last below run first");

   a_alloc_cleared: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) && found |=> !map_ff[$past(idx_ff)] && rsp_valid)
      else $error("allocated sector still marked free");

endmodule
